>>> src/prop_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prop_pkg
// Shared types and constants of the padded rectangle overlap placer.
// ----------------------------------------------------------------------------
package prop_pkg;

  localparam int MAX_RECTS  = 64;
  localparam int COORD_BITS = 12;

  localparam int IN_W     = 12;
  localparam int LEAD_W   = 12;
  localparam int GROW_W   = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W = 2;
  localparam int ROOM_W   = 7;

  localparam int ADDR_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W  = $clog2(MAX_RECTS + 1);

  // signed compare width: stored edge + width + grow margin, plus sign
  localparam int CMP_W = ((COORD_BITS > GROW_W) ? COORD_BITS : GROW_W) + 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_OVERLAP  = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARGIN_LEAD = 2'd0,
    REG_MARGIN_GROW = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
  } rect_t;

  typedef struct packed {
    logic [LEAD_W-1:0] lead;
    logic [GROW_W-1:0] grow;
  } margins_t;

endpackage
`default_nettype wire

>>> src/prop_hit_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prop_hit_check
// Strict overlap test of a proposal against one padded stored rectangle.
// ----------------------------------------------------------------------------
module prop_hit_check (
  input  prop_pkg::rect_t    prop_i,
  input  prop_pkg::rect_t    stored_i,
  input  prop_pkg::margins_t margins_i,
  output logic               hit_o
);
  import prop_pkg::*;

  logic signed [CMP_W-1:0] sl, st, sr, sb;
  logic signed [CMP_W-1:0] pl, pt, pr, pb;
  logic                    x_hit, y_hit;

  always_comb begin
    sl = signed'(CMP_W'(stored_i.left)) - signed'(CMP_W'(margins_i.lead));
    st = signed'(CMP_W'(stored_i.top)) - signed'(CMP_W'(margins_i.lead));
    sr = sl + signed'(CMP_W'(stored_i.width)) + signed'(CMP_W'(margins_i.grow));
    sb = st + signed'(CMP_W'(stored_i.height)) + signed'(CMP_W'(margins_i.grow));
    pl = signed'(CMP_W'(prop_i.left));
    pt = signed'(CMP_W'(prop_i.top));
    pr = pl + signed'(CMP_W'(prop_i.width));
    pb = pt + signed'(CMP_W'(prop_i.height));
    // max(a,b) < min(c,d) as four compares
    x_hit = (pl < pr) && (pl < sr) && (sl < pr) && (sl < sr);
    y_hit = (pt < pb) && (pt < sb) && (st < pb) && (st < sb);
    hit_o = x_hit && y_hit;
  end

endmodule
`default_nettype wire

>>> src/padded_rect_overlap_placer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// padded_rect_overlap_placer_core
// Places rectangles into a table, rejecting any that overlap a padded entry or
// arrive when the table is full. A proposal is taken only while idle; then the
// table memory is scanned through its single read port, one entry per cycle,
// until a hit or the stored count; an empty table skips the scan. The result
// is registered on leaving the decide state, which waits while an earlier one is unread.
// Reset: count cleared, margins to 10 and 20; table contents left as is,
// only entries below the count are ever read.
// ----------------------------------------------------------------------------
module padded_rect_overlap_placer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prop_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [prop_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [prop_pkg::IN_W-1:0]      rect_left_i,
  input  logic [prop_pkg::IN_W-1:0]      rect_top_i,
  input  logic [prop_pkg::IN_W-1:0]      rect_width_i,
  input  logic [prop_pkg::IN_W-1:0]      rect_height_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [prop_pkg::STATUS_W-1:0]  status_o,
  output logic [prop_pkg::ROOM_W-1:0]    room_count_o
);
  import prop_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  state_e               state_q;
  margins_t             margins_q;
  rect_t                prop_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     idx_q;
  logic                 rd_vld_q;
  rect_t                rd_data_q;
  logic                 hit_q;
  logic                 out_valid_q;
  status_e              status_q;
  logic [ROOM_W-1:0]    room_q;

  rect_t                mem [MAX_RECTS];

  logic                 in_fire;
  logic                 issue;
  logic                 hit;
  logic                 decide_fire;
  logic                 full;
  logic                 wr_en;
  status_e              status_d;
  logic [CNT_W-1:0]     count_d;

  prop_hit_check u_hit (
    .prop_i    (prop_q),
    .stored_i  (rd_data_q),
    .margins_i (margins_q),
    .hit_o     (hit)
  );

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign issue        = (state_q == S_SCAN) && (idx_q < count_q);
  assign decide_fire  = (state_q == S_DECIDE) && (!out_valid_q || out_ready_i);
  assign full         = (count_q >= CNT_W'(MAX_RECTS));

  always_comb begin
    if (hit_q) begin
      status_d = ST_OVERLAP;
    end else if (full) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_ACCEPTED;
    end
    wr_en   = decide_fire && (status_d == ST_ACCEPTED);
    count_d = wr_en ? count_q + CNT_W'(1) : count_q;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[ADDR_W-1:0]] <= prop_q;
    end
    if (issue) begin
      rd_data_q <= mem[idx_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prop_q.left   <= COORD_BITS'(rect_left_i);
      prop_q.top    <= COORD_BITS'(rect_top_i);
      prop_q.width  <= COORD_BITS'(rect_width_i);
      prop_q.height <= COORD_BITS'(rect_height_i);
    end
    if (decide_fire) begin
      status_q <= status_d;
      room_q   <= ROOM_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      margins_q.lead <= LEAD_W'(10);
      margins_q.grow <= GROW_W'(20);
      count_q        <= '0;
      idx_q          <= '0;
      rd_vld_q       <= 1'b0;
      hit_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_MARGIN_LEAD: margins_q.lead <= LEAD_W'(cfg_wdata_i);
          REG_MARGIN_GROW: margins_q.grow <= GROW_W'(cfg_wdata_i);
          default: ;
        endcase
      end

      rd_vld_q <= issue;
      if (issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end

      if (decide_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      count_q <= count_d;

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            idx_q <= '0;
            hit_q <= 1'b0;
            state_q <= (count_q == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_vld_q && hit) begin
            hit_q   <= 1'b1;
            state_q <= S_DECIDE;
          end else if (rd_vld_q && !issue) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (decide_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign room_count_o = room_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECTS))
    else $error("stored count beyond table depth");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !full && !hit_q)
    else $error("table write without room or after a hit");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("count did not advance on store");

  a_full_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_FULL) |-> room_q == ROOM_W'(MAX_RECTS))
    else $error("full status with room left");

  a_no_scan_past_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> idx_q < CNT_W'(MAX_RECTS))
    else $error("read beyond table depth");

endmodule
`default_nettype wire
